FILE: rtl/psd_header_section_parser_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the layered-image header parser
// Shared property forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PSD_HEADER_SECTION_PARSER_DEFINES_SVH
`define PSD_HEADER_SECTION_PARSER_DEFINES_SVH

// same-cycle implication
`define PSD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants, record codes, event and record types for the parser.
// ----------------------------------------------------------------------------
package psd_pkg;

	localparam int PB     = 48;
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef logic [PB-1:0] pos_t;

	localparam logic [1:0] REC_HDR = 2'd0;
	localparam logic [1:0] REC_SEC = 2'd1;
	localparam logic [1:0] REC_ERR = 2'd2;

	localparam logic [1:0] ERR_SIG = 2'd0;
	localparam logic [1:0] ERR_VER = 2'd1;
	localparam logic [1:0] ERR_RSV = 2'd2;

	localparam logic [1:0] SEC_CMD = 2'd0;
	localparam logic [1:0] SEC_RES = 2'd1;
	localparam logic [1:0] SEC_LMI = 2'd2;
	localparam logic [1:0] SEC_IMG = 2'd3;

	typedef enum logic [1:0] {EV_HDR, EV_SEC, EV_SECI, EV_ERR} ev_kind_t;

	typedef struct packed {
		ev_kind_t    kind;
		logic [1:0]  id;
		pos_t        off;
		pos_t        len;
		logic [15:0] chn;
		logic [31:0] hgt;
		logic [31:0] wid;
		logic [15:0] dep;
		logic [15:0] mode;
		logic        big;
		logic [1:0]  err;
	} ev_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  id;
		pos_t        off;
		pos_t        len;
		logic [15:0] chn;
		logic [31:0] hgt;
		logic [31:0] wid;
		logic [15:0] dep;
		logic [15:0] mode;
		logic        big;
		logic [1:0]  err;
		logic        last;
	} rec_t;

	function automatic pos_t left_of(pos_t fsize, pos_t pos);
		return (pos < fsize) ? (fsize - pos) : '0;
	endfunction

endpackage

FILE: rtl/psd_queue.sv
// ----------------------------------------------------------------------------
// psd_queue
// Short event queue between the byte classifier and the record builder.
// ----------------------------------------------------------------------------
module psd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  psd_pkg::ev_t  wdata,
	input  logic          pop,
	output psd_pkg::ev_t  rdata,
	output logic          valid,
	output logic          full
);
	import psd_pkg::*;

	ev_t            mem_q [QDEPTH];
	logic [QAW-1:0] wp_q;
	logic [QAW-1:0] rp_q;
	logic [QAW:0]   cnt_q;

	assign valid = (cnt_q != '0);
	assign full  = (cnt_q == (QAW+1)'(QDEPTH));
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

endmodule

FILE: rtl/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front
// Byte classifier: tracks header fields and section lengths, issues events.
// ----------------------------------------------------------------------------
module psd_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [psd_pkg::PB-1:0]   cfg_wr_data,
	input  logic                     in_valid,
	input  logic [7:0]               data_byte,
	input  logic                     first,
	input  logic                     q_full,
	output logic                     in_stall,
	output logic                     ev_push,
	output psd_pkg::ev_t             ev,
	output psd_pkg::pos_t            fsize
);
	import psd_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE, PH_SIG, PH_VER, PH_RSV, PH_HDR, PH_LEN, PH_SKIP, PH_DONE, PH_ERR
	} phase_t;

	localparam logic [31:0] SIG_WORD = "8BPS";
	localparam logic [3:0] SIG_BYTES = 4'd4;
	localparam logic [3:0] VER_BYTES = 4'd2;
	localparam logic [3:0] RSV_BYTES = 4'd6;
	localparam logic [3:0] HID_BYTES = 4'd6;
	localparam logic [3:0] HDR_BYTES = 4'd14;
	localparam logic [3:0] LEN_SHORT = 4'd4;
	localparam logic [3:0] LEN_LONG  = 4'd8;
	localparam logic [15:0] VER_STD  = 16'd1;
	localparam logic [15:0] VER_BIG  = 16'd2;

	function automatic pos_t fit_len(logic [63:0] len, pos_t avail);
		logic [31:0] hi;
		hi = len[63:32];
		if (len[63:PB] == '0 && len[PB-1:0] <= avail)
			return len[PB-1:0];
		if (len[31:0] == '0 && hi != '0 && pos_t'(hi) <= avail)
			return pos_t'(hi);
		return avail;
	endfunction

	phase_t      ph_q, ph_e, ph_n;
	logic [3:0]  cnt_q, cnt_e, cnt_n, cnt_p1;
	logic [63:0] sh_q, sh_e, sh_n;
	logic [47:0] hdr_q, hdr_e, hdr_n;
	logic [63:0] size_q, size_e, size_n;
	pos_t        skip_q, skip_e, skip_n;
	logic [1:0]  idx_q, idx_e, idx_n;
	logic        rsv_q, rsv_e, rsv_n;
	logic        lrg_q, lrg_e, lrg_n;
	pos_t        fs_q, fs_nx;
	pos_t        q1_q, q2_q, avl_q, sel;
	pos_t        len_c;
	logic [3:0]  need;
	logic        acc, act;
	ev_t         ev_c;
	logic        push_c;

	assign in_stall = q_full;
	assign acc      = in_valid && !in_stall;
	assign fsize    = fs_q;
	assign ev       = ev_c;
	assign ev_push  = push_c;

	always_comb begin
		ph_e   = first ? PH_SIG : ph_q;
		cnt_e  = first ? '0 : cnt_q;
		sh_e   = first ? '0 : sh_q;
		hdr_e  = first ? '0 : hdr_q;
		size_e = first ? '0 : size_q;
		skip_e = first ? '0 : skip_q;
		idx_e  = first ? '0 : idx_q;
		rsv_e  = first ? 1'b0 : rsv_q;
		lrg_e  = first ? 1'b0 : lrg_q;
		act    = acc && !(ph_e inside {PH_IDLE, PH_DONE, PH_ERR});
		cnt_p1 = cnt_e + 1'b1;
		need   = (idx_e >= 2'd2 && lrg_e) ? LEN_LONG : LEN_SHORT;
		ph_n   = ph_e;
		cnt_n  = cnt_p1;
		sh_n   = sh_e;
		hdr_n  = hdr_e;
		size_n = size_e;
		skip_n = skip_e;
		idx_n  = idx_e;
		rsv_n  = rsv_e;
		lrg_n  = lrg_e;
		len_c  = fit_len({size_e[55:0], data_byte}, avl_q);
		push_c = 1'b0;
		ev_c   = '0;
		case (ph_e)
			PH_SIG: begin
				sh_n = {sh_e[55:0], data_byte};
				if (cnt_p1 == SIG_BYTES) begin
					cnt_n = '0;
					if (sh_n[31:0] != SIG_WORD) begin
						ph_n       = PH_ERR;
						push_c     = 1'b1;
						ev_c.kind  = EV_ERR;
						ev_c.err   = ERR_SIG;
					end else begin
						ph_n = PH_VER;
						sh_n = '0;
					end
				end
			end
			PH_VER: begin
				sh_n = {sh_e[55:0], data_byte};
				if (cnt_p1 == VER_BYTES) begin
					cnt_n = '0;
					if (sh_n[15:0] != VER_STD && sh_n[15:0] != VER_BIG) begin
						ph_n       = PH_ERR;
						push_c     = 1'b1;
						ev_c.kind  = EV_ERR;
						ev_c.err   = ERR_VER;
					end else begin
						lrg_n = (sh_n[15:0] == VER_BIG);
						ph_n  = PH_RSV;
						sh_n  = '0;
					end
				end
			end
			PH_RSV: begin
				rsv_n = rsv_e | (data_byte != 8'h00);
				if (cnt_p1 == RSV_BYTES) begin
					cnt_n = '0;
					if (rsv_n) begin
						ph_n       = PH_ERR;
						push_c     = 1'b1;
						ev_c.kind  = EV_ERR;
						ev_c.err   = ERR_RSV;
					end else begin
						ph_n  = PH_HDR;
						hdr_n = '0;
						sh_n  = '0;
					end
				end
			end
			PH_HDR: begin
				if (cnt_e < HID_BYTES)
					hdr_n = {hdr_e[39:0], data_byte};
				else
					sh_n = {sh_e[55:0], data_byte};
				if (cnt_p1 == HDR_BYTES) begin
					cnt_n      = '0;
					ph_n       = PH_LEN;
					idx_n      = '0;
					size_n     = '0;
					push_c     = 1'b1;
					ev_c.kind  = EV_HDR;
					ev_c.chn   = hdr_n[47:32];
					ev_c.hgt   = hdr_n[31:0];
					ev_c.wid   = sh_n[63:32];
					ev_c.dep   = sh_n[31:16];
					ev_c.mode  = sh_n[15:0];
					ev_c.big   = lrg_e;
				end
			end
			PH_LEN: begin
				size_n = {size_e[55:0], data_byte};
				if (cnt_p1 == need) begin
					cnt_n    = '0;
					size_n   = '0;
					push_c   = 1'b1;
					ev_c.id  = idx_e;
					ev_c.off = q1_q;
					ev_c.len = len_c;
					if (idx_e >= 2'd2) begin
						ev_c.kind = EV_SECI;
						ph_n      = PH_DONE;
					end else begin
						ev_c.kind = EV_SEC;
						if (len_c == '0) begin
							idx_n = idx_e + 1'b1;
						end else begin
							skip_n = len_c;
							ph_n   = PH_SKIP;
						end
					end
				end
			end
			PH_SKIP: begin
				skip_n = (skip_e != '0) ? skip_e - 1'b1 : skip_e;
				if (skip_n == '0) begin
					idx_n  = idx_e + 1'b1;
					ph_n   = PH_LEN;
					cnt_n  = '0;
					size_n = '0;
				end
			end
			default: begin
				cnt_n = cnt_e;
			end
		endcase
		push_c = push_c && act;
	end

	always_comb begin
		fs_nx = cfg_wr_en ? cfg_wr_data : fs_q;
		if (act)
			sel = first ? pos_t'(2) : q2_q;
		else
			sel = q1_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			cnt_q  <= '0;
			sh_q   <= '0;
			hdr_q  <= '0;
			size_q <= '0;
			skip_q <= '0;
			idx_q  <= '0;
			rsv_q  <= 1'b0;
			lrg_q  <= 1'b0;
			fs_q   <= '0;
			q1_q   <= pos_t'(1);
			q2_q   <= pos_t'(2);
			avl_q  <= '0;
		end else begin
			fs_q  <= fs_nx;
			avl_q <= left_of(fs_nx, sel);
			if (act) begin
				ph_q   <= ph_n;
				cnt_q  <= cnt_n;
				sh_q   <= sh_n;
				hdr_q  <= hdr_n;
				size_q <= size_n;
				skip_q <= skip_n;
				idx_q  <= idx_n;
				rsv_q  <= rsv_n;
				lrg_q  <= lrg_n;
				if (first) begin
					q1_q <= pos_t'(2);
					q2_q <= pos_t'(3);
				end else begin
					q1_q <= q2_q;
					q2_q <= q2_q + 1'b1;
				end
			end
		end
	end

endmodule

FILE: rtl/psd_back.sv
// ----------------------------------------------------------------------------
// psd_back
// Record builder: turns queued events into output records, adds the image data section record.
// ----------------------------------------------------------------------------
module psd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  psd_pkg::ev_t   q_data,
	input  psd_pkg::pos_t  fsize,
	input  logic           out_stall,
	output logic           q_pop,
	output logic           out_valid,
	output psd_pkg::rec_t  rec
);
	import psd_pkg::*;

	logic ovld_q;
	logic pend_q;
	pos_t img_q;
	rec_t rec_q;
	rec_t rec_c;
	rec_t img_c;
	logic free;

	assign free      = !ovld_q || !out_stall;
	assign q_pop     = q_valid && !pend_q && free;
	assign out_valid = ovld_q;
	assign rec       = rec_q;

	always_comb begin
		rec_c = '0;
		case (q_data.kind)
			EV_HDR: begin
				rec_c.kind  = REC_HDR;
				rec_c.chn   = q_data.chn;
				rec_c.hgt   = q_data.hgt;
				rec_c.wid   = q_data.wid;
				rec_c.dep   = q_data.dep;
				rec_c.mode  = q_data.mode;
				rec_c.big   = q_data.big;
				rec_c.last  = 1'b1;
			end
			EV_SEC, EV_SECI: begin
				rec_c.kind = REC_SEC;
				rec_c.id   = q_data.id;
				rec_c.off  = q_data.off;
				rec_c.len  = q_data.len;
				rec_c.last = (q_data.kind == EV_SEC);
			end
			EV_ERR: begin
				rec_c.kind = REC_ERR;
				rec_c.err  = q_data.err;
				rec_c.last = 1'b1;
			end
			default: begin
				rec_c = '0;
			end
		endcase
		img_c      = '0;
		img_c.kind = REC_SEC;
		img_c.id   = SEC_IMG;
		img_c.off  = img_q;
		img_c.len  = left_of(fsize, img_q);
		img_c.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
			pend_q <= 1'b0;
		end else if (free) begin
			if (pend_q) begin
				ovld_q <= 1'b1;
				pend_q <= 1'b0;
			end else if (q_valid) begin
				ovld_q <= 1'b1;
				pend_q <= (q_data.kind == EV_SECI);
			end else begin
				ovld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free && pend_q)
			rec_q <= img_c;
		else if (q_pop)
			rec_q <= rec_c;
		if (q_pop)
			img_q <= q_data.off + q_data.len;
	end

endmodule

FILE: rtl/psd_header_section_parser.sv
// ----------------------------------------------------------------------------
// psd_header_section_parser: layered-image file header and section parser
// Events pass via the queue to the record register; the image record follows.
// One byte per cycle unless in_stall; a 4-deep queue absorbs output stalls.
// Reset: async clears parse state and file_size to 0; no clearing pass.
// ----------------------------------------------------------------------------
`include "psd_header_section_parser_defines.svh"

module psd_header_section_parser (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [psd_pkg::PB-1:0]  cfg_wr_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [7:0]              data_byte,
	input  logic                    first,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              record_kind,
	output logic [1:0]              section_id,
	output logic [psd_pkg::PB-1:0]  section_offset,
	output logic [psd_pkg::PB-1:0]  section_length,
	output logic [15:0]             channel_count,
	output logic [31:0]             image_height,
	output logic [31:0]             image_width,
	output logic [15:0]             bits_per_channel,
	output logic [15:0]             color_mode,
	output logic                    is_large,
	output logic [1:0]              error_code,
	output logic                    last
);
	import psd_pkg::*;

	logic ev_push;
	ev_t  ev_w;
	ev_t  ev_r;
	logic q_valid;
	logic q_full;
	logic q_pop;
	pos_t fsize;
	rec_t rec;

	psd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.data_byte   (data_byte),
		.first       (first),
		.q_full      (q_full),
		.in_stall    (in_stall),
		.ev_push     (ev_push),
		.ev          (ev_w),
		.fsize       (fsize)
	);

	psd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (ev_push),
		.wdata  (ev_w),
		.pop    (q_pop),
		.rdata  (ev_r),
		.valid  (q_valid),
		.full   (q_full)
	);

	psd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (ev_r),
		.fsize     (fsize),
		.out_stall (out_stall),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.rec       (rec)
	);

	assign record_kind      = rec.kind;
	assign section_id       = rec.id;
	assign section_offset   = rec.off;
	assign section_length   = rec.len;
	assign channel_count    = rec.chn;
	assign image_height     = rec.hgt;
	assign image_width      = rec.wid;
	assign bits_per_channel = rec.dep;
	assign color_mode       = rec.mode;
	assign is_large         = rec.big;
	assign error_code       = rec.err;
	assign last             = rec.last;

	`PSD_ASSERT_NOW(a_no_overflow, ev_push, !q_full, "event pushed into full queue")
	`PSD_ASSERT_NOW(a_err_single, out_valid && record_kind == REC_ERR, last,
		"error record not marked last")
	`PSD_ASSERT_NEXT(a_img_follows, out_valid && !last && !out_stall,
		out_valid && last && section_id == SEC_IMG, "image record missing after layer info")
	`PSD_ASSERT_NEXT(a_pair_holds, out_valid && !last, out_valid, "record pair broken")

endmodule
